// ----- rtl/core/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared widths, operation codes, status codes and the response record
// of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int FUNC_W       = 3;
   localparam int POS_W        = 5;
   localparam int VAL_W        = 8;
   localparam int STAT_W       = 2;
   localparam int CNT_OUT_W    = 5;
   localparam int CAPACITY_DEF = 16;

   localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      status_type           status;
      logic [VAL_W-1:0]     read_value;
      logic [POS_W-1:0]     found_position;
      logic [CNT_OUT_W-1:0] count;
      logic                 is_empty;
   } rsp_type;

endpackage

// ----- rtl/core/sle_if.sv -----
// ----------------------------------------------------------------------------
// sle_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sle_req_if;
   logic                         valid;
   logic                         ready;
   logic [sle_pkg::FUNC_W-1:0]   func;
   logic [sle_pkg::POS_W-1:0]    position;
   logic [sle_pkg::VAL_W-1:0]    value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface sle_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sle_pkg::STAT_W-1:0]    status;
   logic [sle_pkg::VAL_W-1:0]     read_value;
   logic [sle_pkg::POS_W-1:0]     found_position;
   logic [sle_pkg::CNT_OUT_W-1:0] count;
   logic                          is_empty;

   modport source (output valid, output status, output read_value, output found_position,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input found_position,
                   input count, input is_empty, output ready);
endinterface

// ----- rtl/core/sle_store.sv -----
// ----------------------------------------------------------------------------
// sle_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_store #(
   parameter int DEPTH = sle_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(sle_pkg::CAPACITY_DEF)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [sle_pkg::VAL_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [sle_pkg::VAL_W-1:0] wr_data
);
   import sle_pkg::*;

   logic [VAL_W-1:0] store_ff [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sle_ctrl.sv -----
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: range checks, store walk for insert, delete, read and
// find, element count and response register.
// ----------------------------------------------------------------------------
module sle_ctrl #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(sle_pkg::CAPACITY_DEF)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [sle_pkg::FUNC_W-1:0] req_func,
   input  logic [sle_pkg::POS_W-1:0]  req_position,
   input  logic [sle_pkg::VAL_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sle_pkg::rsp_type           rsp_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [sle_pkg::VAL_W-1:0]  mem_rd_data,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [sle_pkg::VAL_W-1:0]  mem_wr_data
);
   import sle_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [AW-1:0]     fin_addr_ff, fin_addr_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     left_ff, left_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     paddr_ff, paddr_in;
   logic [CW-1:0]     count_ff, count_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [XW-1:0]     pos_x, cnt_x, pos_m1, fpos_x;
   logic              full, ins_ok, idx_ok, finish;

   function automatic rsp_type mk_rsp(status_type st, logic [VAL_W-1:0] rd,
                                      logic [POS_W-1:0] fp, logic [CW-1:0] cnt);
      rsp_type r;
      logic [XW-1:0] cx;
      cx               = XW'(cnt);
      r.status         = st;
      r.read_value     = rd;
      r.found_position = fp;
      r.count          = cx[CNT_OUT_W-1:0];
      r.is_empty       = (cnt == '0);
      return r;
   endfunction

   assign pos_x  = XW'(req_position);
   assign cnt_x  = XW'(count_ff);
   assign pos_m1 = pos_x - 1'b1;
   assign full   = (cnt_x >= CAP_X);
   assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
   assign idx_ok = (pos_x != '0) && (pos_x <= cnt_x);
   assign fpos_x = XW'(paddr_ff) + 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      fin_addr_in  = fin_addr_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      paddr_in     = paddr_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ptr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = fin_addr_ff;
      mem_wr_data  = val_ff;
      finish       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_func;
               val_in      = req_value;
               fin_addr_in = pos_m1[AW-1:0];
               pend_in     = 1'b0;
               state_in    = S_DONE;
               res_in      = mk_rsp(ST_OK, '0, '0, count_ff);
               unique case (req_func)
                  FN_APPEND: begin
                     if (full) begin
                        res_in = mk_rsp(ST_FULL, '0, '0, count_ff);
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = req_value;
                        count_in    = count_ff + 1'b1;
                        res_in      = mk_rsp(ST_OK, '0, '0, CW'(count_ff + 1'b1));
                     end
                  end
                  FN_INSERT: begin
                     if (full) begin
                        res_in = mk_rsp(ST_FULL, '0, '0, count_ff);
                     end else if (!ins_ok) begin
                        res_in = mk_rsp(ST_RANGE, '0, '0, count_ff);
                     end else begin
                        state_in = S_WALK;
                        ptr_in   = AW'(cnt_x - 1'b1);
                        left_in  = CW'(cnt_x - pos_m1);
                     end
                  end
                  FN_DELETE: begin
                     if (!idx_ok) begin
                        res_in = mk_rsp(ST_RANGE, '0, '0, count_ff);
                     end else begin
                        state_in = S_WALK;
                        ptr_in   = pos_x[AW-1:0];
                        left_in  = CW'(cnt_x - pos_x);
                     end
                  end
                  FN_READ: begin
                     if (!idx_ok) begin
                        res_in = mk_rsp(ST_RANGE, '0, '0, count_ff);
                     end else begin
                        state_in = S_WALK;
                        ptr_in   = pos_m1[AW-1:0];
                        left_in  = CW'(1);
                     end
                  end
                  FN_FIND: begin
                     state_in = S_WALK;
                     ptr_in   = '0;
                     left_in  = count_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (pend_ff) begin
               case (op_ff)
                  FN_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(paddr_ff + 1'b1);
                     mem_wr_data = mem_rd_data;
                  end
                  FN_DELETE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(paddr_ff - 1'b1);
                     mem_wr_data = mem_rd_data;
                  end
                  FN_READ: begin
                     finish = 1'b1;
                     res_in = mk_rsp(ST_OK, mem_rd_data, '0, count_ff);
                  end
                  FN_FIND: begin
                     if (mem_rd_data == val_ff) begin
                        finish = 1'b1;
                        res_in = mk_rsp(ST_OK, '0, fpos_x[POS_W-1:0], count_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (!finish && left_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff;
               paddr_in    = ptr_ff;
               pend_in     = 1'b1;
               left_in     = left_ff - 1'b1;
               ptr_in      = (op_ff == FN_INSERT) ? AW'(ptr_ff - 1'b1) : AW'(ptr_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
            end
            if (finish) begin
               state_in = S_DONE;
            end else if (left_ff == '0 && !pend_ff) begin
               state_in = S_DONE;
               case (op_ff)
                  FN_INSERT: begin
                     // last shift is written; place the new element
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = fin_addr_ff;
                     mem_wr_data = val_ff;
                     count_in    = count_ff + 1'b1;
                     res_in      = mk_rsp(ST_OK, '0, '0, CW'(count_ff + 1'b1));
                  end
                  FN_DELETE: begin
                     count_in = count_ff - 1'b1;
                     res_in   = mk_rsp(ST_OK, '0, '0, CW'(count_ff - 1'b1));
                  end
                  FN_FIND: begin
                     res_in = mk_rsp(ST_NOTFOUND, '0, '0, count_ff);
                  end
                  default: begin
                     res_in = mk_rsp(ST_OK, '0, '0, count_ff);
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff       <= op_in;
      val_ff      <= val_in;
      fin_addr_ff <= fin_addr_in;
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      paddr_ff    <= paddr_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(count_ff) <= CAP_X)
      else $error("element count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + 1'b1) ||
                        (count_ff == $past(count_ff) - 1'b1))
      else $error("element count moved by more than one");

   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("store read and write hit the same entry");

   a_pend_src: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(mem_rd_en))
      else $error("pending read data without a read");
`endif

endmodule

// ----- rtl/core/sequential_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// sequential_list_engine_unit
// Ordered byte list in a single-port-read, single-port-write store:
// append, insert, delete, read and find.
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  req_chan  in    func, position, value
//  rsp_chan  out   status, read_value, found_position, count, is_empty
//
//  Append and rejected requests go from idle straight to the response
//  register; read, insert, delete and find first walk the store, which
//  moves one element per cycle through its one read and one write port.
//  Find stops at the first match and walks the whole list on a miss.
//  Reset clears the count; the store itself is not cleared.
//  A new request is taken while the previous response waits on rsp_chan.
module sequential_list_engine_unit #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
   input logic   clock,
   input logic   reset,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);
   import sle_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic              mem_rd_en, mem_wr_en;
   logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
   logic [VAL_W-1:0]  mem_rd_data, mem_wr_data;
   rsp_type           rsp_data;

   sle_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_func     (req_chan.func),
      .req_position (req_chan.position),
      .req_value    (req_chan.value),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_data     (rsp_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   sle_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign rsp_chan.status         = rsp_data.status;
   assign rsp_chan.read_value     = rsp_data.read_value;
   assign rsp_chan.found_position = rsp_data.found_position;
   assign rsp_chan.count          = rsp_data.count;
   assign rsp_chan.is_empty       = rsp_data.is_empty;

endmodule
